FILE: src/sbst_pkg.sv
package sbst_pkg;

    // Fixed-point format of fractions along the segment
    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;     // unsigned Q1.FRAC_BITS
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;       // exact coordinate difference
    localparam int REM_W     = DIFF_W + 1;        // partial remainder, below 2*den
    localparam int AXES      = 3;
    localparam int LANES     = 2 * AXES;          // entry lanes 0..2, exit lanes 3..5
    localparam int DIV_STAGES = FX_W;             // one quotient bit per stage

    localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } query_t;

    typedef struct packed {
        logic            hit;
        logic [FX_W-1:0] hit_time;
    } result_t;

    // One divider lane: remainder, divisor, quotient bits so far
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIFF_W-1:0] den;
        logic [FX_W-1:0]   quo;
    } div_lane_t;

    // Transaction in flight through the divider pipeline
    typedef struct packed {
        logic                  valid;
        logic                  miss;
        logic [AXES-1:0]       use_st;
        logic [AXES-1:0]       use_et;
        div_lane_t [LANES-1:0] lane;
    } pipe_t;

endpackage

FILE: src/sbst_setup.sv
module sbst_setup
    import sbst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  query_t query,
    output pipe_t  pipe_out
);

    pipe_t pipe_reg;
    pipe_t pipe_next;

    logic signed [COORD_W-1:0] s_c  [AXES];
    logic signed [COORD_W-1:0] e_c  [AXES];
    logic signed [COORD_W-1:0] lo_c [AXES];
    logic signed [COORD_W-1:0] hi_c [AXES];

    // Gather coordinates per axis
    always_comb
    begin
        s_c[0]  = query.start_x;   s_c[1]  = query.start_y;   s_c[2]  = query.start_z;
        e_c[0]  = query.end_x;     e_c[1]  = query.end_y;     e_c[2]  = query.end_z;
        lo_c[0] = query.box_min_x; lo_c[1] = query.box_min_y; lo_c[2] = query.box_min_z;
        hi_c[0] = query.box_max_x; hi_c[1] = query.box_max_y; hi_c[2] = query.box_max_z;
    end

    // Early reject, slab numerators and divisors per axis
    always_comb
    begin
        logic signed [DIFF_W-1:0] s, e, lo, hi;
        logic [DIFF_W-1:0] d, n_st, n_et;
        logic u_st, u_et;
        pipe_next       = '0;
        pipe_next.valid = start;
        for (int ax = 0; ax < AXES; ax++)
        begin
            s  = DIFF_W'(s_c[ax]);
            e  = DIFF_W'(e_c[ax]);
            lo = DIFF_W'(lo_c[ax]);
            hi = DIFF_W'(hi_c[ax]);
            if (s < e)
            begin
                d    = DIFF_W'(e - s);
                n_st = DIFF_W'(lo - s);
                n_et = DIFF_W'(hi - s);
                u_st = (s < lo);
                u_et = (e > hi);
                if (s > hi || e < lo)
                    pipe_next.miss = 1'b1;
            end
            else
            begin
                d    = DIFF_W'(s - e);
                n_st = DIFF_W'(s - hi);
                n_et = DIFF_W'(s - lo);
                u_st = (s > hi);
                u_et = (e < lo);
                if (e > hi || s < lo)
                    pipe_next.miss = 1'b1;
            end
            pipe_next.use_st[ax] = u_st;
            pipe_next.use_et[ax] = u_et;
            // unused lanes divide 0 by 1 to stay well defined
            pipe_next.lane[ax].rem        = u_st ? REM_W'(n_st) : '0;
            pipe_next.lane[ax].den        = u_st ? d : DIFF_W'(1);
            pipe_next.lane[ax].quo        = '0;
            pipe_next.lane[AXES+ax].rem   = u_et ? REM_W'(n_et) : '0;
            pipe_next.lane[AXES+ax].den   = u_et ? d : DIFF_W'(1);
            pipe_next.lane[AXES+ax].quo   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg <= '0;
        else
            pipe_reg <= pipe_next;
    end

    assign pipe_out = pipe_reg;

endmodule

FILE: src/sbst_div_stage.sv
module sbst_div_stage
    import sbst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pipe_t pipe_in,
    output pipe_t pipe_out
);

    pipe_t pipe_reg;
    pipe_t pipe_next;

    // One restoring-division step on every lane: compare, subtract, shift
    always_comb
    begin
        logic [REM_W-1:0] r;
        logic             q_bit;
        pipe_next = pipe_in;
        for (int ln = 0; ln < LANES; ln++)
        begin
            q_bit = (pipe_in.lane[ln].rem >= REM_W'(pipe_in.lane[ln].den));
            r     = q_bit ? pipe_in.lane[ln].rem - REM_W'(pipe_in.lane[ln].den)
                          : pipe_in.lane[ln].rem;
            pipe_next.lane[ln].rem = {r[REM_W-2:0], 1'b0};
            pipe_next.lane[ln].quo = {pipe_in.lane[ln].quo[FX_W-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg <= '0;
        else
            pipe_reg <= pipe_next;
    end

    assign pipe_out = pipe_reg;

endmodule

FILE: src/sbst_merge.sv
module sbst_merge
    import sbst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  pipe_t   pipe_in,
    output logic    done,
    output result_t result
);

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    // Narrow the interval [0, 1] axis by axis
    always_comb
    begin
        logic [FX_W-1:0] fst, fet, st, et;
        logic            miss;
        fst  = '0;
        fet  = ONE_FX;
        miss = pipe_in.miss;
        for (int ax = 0; ax < AXES; ax++)
        begin
            st = pipe_in.use_st[ax] ? pipe_in.lane[ax].quo : '0;
            et = pipe_in.use_et[ax] ? pipe_in.lane[AXES+ax].quo : ONE_FX;
            if (st > fst)
                fst = st;
            if (et < fet)
                fet = et;
            if (fet < fst)
                miss = 1'b1;
        end
        result_next.hit      = !miss;
        result_next.hit_time = miss ? '0 : fst;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pipe_in.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/segment_box_slab_test.sv
// Segment against axis-aligned box, slab test, fully pipelined.
// Pipeline from start to done: setup, 17 divider bit stages, merge.
// Throughput: one transaction per cycle; busy stays low, set by one quotient
// bit per divider stage across six parallel lanes.
// Reset: rst_n asynchronous, clears all valid bits; no transaction is in flight.
// The receiver cannot stall: each result shows for one cycle with done.
module segment_box_slab_test
    import sbst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  query_t  query,
    output logic    done,
    output result_t result
);

    pipe_t pipe_c [DIV_STAGES+1];

    assign busy = 1'b0;

    // Differences, early reject, divider operands
    sbst_setup u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .query    (query),
        .pipe_out (pipe_c[0])
    );

    // Divider pipeline, one quotient bit per stage
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        sbst_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .pipe_in  (pipe_c[g]),
            .pipe_out (pipe_c[g+1])
        );
    end

    // Interval narrowing and result register
    sbst_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .pipe_in (pipe_c[DIV_STAGES]),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: tb/segment_box_slab_test_tb.sv
`timescale 1ns / 100ps

module segment_box_slab_test_tb;
    import sbst_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    query_t  query;
    logic    done;
    result_t result;

    result_t hit_q[$];
    int      fail_cnt;

    segment_box_slab_test uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Fraction floor(num * 2^FRAC_BITS / den), clamped to 1.0
    function automatic logic [FX_W-1:0] slab_frac(longint unsigned num, longint unsigned den);
        longint unsigned q;
        if (den == 0)
            return ONE_FX;
        if (num > den)
            num = den;
        q = (num << FRAC_BITS) / den;
        return (q > ONE_FX) ? ONE_FX : FX_W'(q);
    endfunction

    // Slab-test predictor
    function automatic result_t slab_predict(query_t qi);
        logic signed [COORD_W-1:0] sv[AXES], ev[AXES], lov[AXES], hiv[AXES];
        longint s, e, lo, hi;
        longint unsigned fst, fet, st, et, d;
        result_t r;
        sv  = '{qi.start_x, qi.start_y, qi.start_z};
        ev  = '{qi.end_x, qi.end_y, qi.end_z};
        lov = '{qi.box_min_x, qi.box_min_y, qi.box_min_z};
        hiv = '{qi.box_max_x, qi.box_max_y, qi.box_max_z};
        fst = 0;
        fet = ONE_FX;
        r = '0;
        for (int ax = 0; ax < AXES; ax++)
        begin
            s = sv[ax]; e = ev[ax]; lo = lov[ax]; hi = hiv[ax];
            st = 0;
            et = ONE_FX;
            if (s < e)
            begin
                d = e - s;
                if (s > hi || e < lo)
                    return r;
                if (s < lo) st = slab_frac(lo - s, d);
                if (e > hi) et = slab_frac(hi - s, d);
            end
            else
            begin
                d = s - e;
                if (e > hi || s < lo)
                    return r;
                if (s > hi) st = slab_frac(s - hi, d);
                if (e < lo) et = slab_frac(s - lo, d);
            end
            if (st > fst) fst = st;
            if (et < fet) fet = et;
            if (fet < fst)
                return r;
        end
        r.hit = 1'b1;
        r.hit_time = FX_W'(fst);
        return r;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (hit_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                fail_cnt++;
            end
            else
            begin
                want = hit_q.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, result.hit);
                    fail_cnt++;
                end
                if (result.hit_time !== want.hit_time)
                begin
                    $display("%0t: hit_time expected %h actual %h", $time,
                             want.hit_time, result.hit_time);
                    fail_cnt++;
                end
            end
        end
    end

    // Directed rows: query, typed expectation, whether it is typed
    typedef struct {
        query_t  q;
        result_t r;
        bit      typed;
    } dir_row_t;

    localparam logic signed [31:0] ONE_C = 32'sh0001_0000;
    localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;

    function automatic query_t mk_query(logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                        lx, ly, lz, hx, hy, hz);
        query_t q;
        q = '{sx, sy, sz, ex, ey, ez, lx, ly, lz, hx, hy, hz};
        return q;
    endfunction

    function automatic logic signed [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
            2: return ($urandom_range(0, 1)) ? MAX_C - $urandom_range(0, 3)
                                             : MIN_C + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 16)) - 8;
        endcase
    endfunction

    // Random query, a quarter of them boxes straddled by segments
    function automatic query_t rnd_query();
        logic signed [31:0] c[12];
        logic signed [31:0] a;
        int mode, kind;
        query_t q;
        mode = $urandom_range(0, 9);
        mode = (mode < 1) ? 0 : (mode < 2) ? 2 : (mode < 3) ? 3 : 1;
        kind = $urandom_range(0, 3);
        for (int i = 0; i < 12; i++)
            c[i] = rnd_coord(mode);
        for (int ax = 0; ax < 3; ax++)
        begin
            if (kind != 0 && c[6 + ax] > c[9 + ax])
            begin
                a = c[6 + ax]; c[6 + ax] = c[9 + ax]; c[9 + ax] = a;
            end
            if ($urandom_range(0, 15) == 0)
                c[3 + ax] = c[ax];
            if (kind == 2)
            begin
                c[ax] = c[6 + ax] - $signed($urandom_range(0, 65536));
                c[3 + ax] = c[9 + ax] + $signed($urandom_range(0, 65536));
                if ($urandom_range(0, 1)) begin a = c[ax]; c[ax] = c[3 + ax]; c[3 + ax] = a; end
            end
        end
        q = mk_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]);
        return q;
    endfunction

    task automatic send_query(query_t q, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        query <= q;
        hit_q.push_back(slab_predict(q));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        result_t  miss_r, hit0_r;
        int       wait_cnt;
        int       idle_pct;
        miss_r = '0;
        hit0_r = '{hit: 1'b1, hit_time: '0};
        fail_cnt = 0;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;

        // all zero: point on a point box
        rows.push_back('{mk_query(0,0,0,0,0,0,0,0,0,0,0,0), hit0_r, 1});
        // start inside unit box
        rows.push_back('{mk_query(0,0,0,ONE_C,ONE_C,ONE_C,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), hit0_r, 1});
        // both ends beyond upper x face
        rows.push_back('{mk_query(2*ONE_C,0,0,3*ONE_C,0,0,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), miss_r, 1});
        // both ends below lower y face
        rows.push_back('{mk_query(0,-3*ONE_C,0,0,-2*ONE_C,0,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), miss_r, 1});
        // degenerate point outside
        rows.push_back('{mk_query(0,0,5*ONE_C,0,0,5*ONE_C,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), miss_r, 1});
        // entry half-way along x
        rows.push_back('{mk_query(-3*ONE_C,0,0,ONE_C,0,0,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), '{1'b1, 17'h08000}, 1});
        // reversed entry from above
        rows.push_back('{mk_query(0,0,3*ONE_C,0,0,-ONE_C,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), '{1'b1, 17'h08000}, 1});
        // touching at end: entry fraction 1.0
        rows.push_back('{mk_query(-2*ONE_C,0,0,-ONE_C,0,0,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), '{1'b1, 17'h10000}, 1});
        // interval empty across axes
        rows.push_back('{mk_query(-3*ONE_C,ONE_C/2,0,0,4*ONE_C,0,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), '{1'b0, '0}, 0});
        // full-range extremes
        rows.push_back('{mk_query(MIN_C,MIN_C,MIN_C,MAX_C,MAX_C,MAX_C,-ONE_C,-ONE_C,-ONE_C,
                                  ONE_C,ONE_C,ONE_C), '{1'b0, '0}, 0});
        rows.push_back('{mk_query(MAX_C,MAX_C,MAX_C,MIN_C,MIN_C,MIN_C,MIN_C,MIN_C,MIN_C,
                                  MAX_C,MAX_C,MAX_C), hit0_r, 1});
        rows.push_back('{mk_query(MIN_C,MIN_C,MIN_C,MAX_C,MAX_C,MAX_C,MAX_C,MAX_C,MAX_C,
                                  MAX_C,MAX_C,MAX_C), '{1'b1, 17'h10000}, 1});
        rows.push_back('{mk_query(MAX_C,MAX_C,MAX_C,MAX_C,MAX_C,MAX_C,MIN_C,MIN_C,MIN_C,
                                  MIN_C,MIN_C,MIN_C), miss_r, 1});
        // inverted boxes
        rows.push_back('{mk_query(-3*ONE_C,0,0,3*ONE_C,0,0,ONE_C,ONE_C,ONE_C,
                                  -ONE_C,-ONE_C,-ONE_C), '{1'b0, '0}, 0});
        rows.push_back('{mk_query(0,0,0,0,0,0,ONE_C,0,0,-ONE_C,0,0), '{1'b0, '0}, 0});
        rows.push_back('{mk_query(-ONE_C,-ONE_C,-ONE_C,-1,-1,-1,MIN_C,MIN_C,MIN_C,
                                  -ONE_C,-ONE_C,-ONE_C), '{1'b0, '0}, 0});
        // all ones pattern
        rows.push_back('{mk_query(-1,-1,-1,-1,-1,-1,-1,-1,-1,-1,-1,-1), hit0_r, 1});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.typed && slab_predict(row.q) !== row.r)
            begin
                $display("%0t: row %0d expected %h actual %h", $time, i, row.r,
                         slab_predict(row.q));
                fail_cnt++;
            end
            send_query(row.q, 0);
        end

        // Random phases
        for (int n = 0; n < 1850; n++)
        begin
            case ((n / 300) % 4)
                0: idle_pct = 0;
                1: idle_pct = 46;
                2: idle_pct = 0;
                default: idle_pct = 11;
            endcase
            send_query(rnd_query(), idle_pct);
        end
        start <= 1'b0;

        // Drain
        wait_cnt = 0;
        while (hit_q.size() != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (25) @(posedge clk);
        if (fail_cnt == 0 && hit_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
